@@ sv/waveform_column_envelope_defines.svh @@
// assertion macros for the waveform column envelope checker
// expects a clock and an active-high synchronous reset named clock and reset in scope
`ifndef WAVEFORM_COLUMN_ENVELOPE_DEFINES_SVH
`define WAVEFORM_COLUMN_ENVELOPE_DEFINES_SVH

// condition holds at every edge outside reset
`define WCE_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds at the next edge after the antecedent
`define WCE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent holds at the next edge after reset is seen
`define WCE_ASSERT_AFTER_RESET(name, cons, msg) \
   name: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

@@ sv/wce_pkg.sv @@
// shared types and constants for the waveform column envelope
// no dependencies
package wce_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 16;
   localparam int PEAK_BITS   = SAMPLE_BITS - 1;
   localparam int SUM_BITS    = 32;
   localparam int STEP_BITS   = $clog2(SUM_BITS);

   localparam logic [COUNT_BITS-1:0] COLUMN_SIZE_RESET = COUNT_BITS'(256);

   // input beat
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_type;

   // result beat
   typedef struct packed {
      logic        [COUNT_BITS-1:0]  column_index;
      logic        [PEAK_BITS-1:0]   peak_high;
      logic signed [SAMPLE_BITS-1:0] peak_low;
      logic        [PEAK_BITS-1:0]   average_high;
      logic signed [SAMPLE_BITS-1:0] average_low;
   } rsp_type;

   // finished column waiting for division
   typedef struct packed {
      logic        [COUNT_BITS-1:0]  column_index;
      logic        [PEAK_BITS-1:0]   peak_high;
      logic signed [SAMPLE_BITS-1:0] peak_low;
      logic        [SUM_BITS-1:0]    positive_sum;
      logic        [SUM_BITS-1:0]    negative_mag;
      logic        [COUNT_BITS-1:0]  divisor;
   } job_type;

   // queue write side
   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ sv/waveform_column_envelope.sv @@
// channel  direction  handshake        payload
// req      in         valid / stall    req_type: sample, last_sample
// rsp      out        valid / stall    rsp_type: column, peaks, averages
// csr      in         valid / ready    16-bit samples per column, always ready
//
// the front end takes one sample beat every cycle while req_stall is low and folds it into the column
// each column then passes through the back end: load, 32 divider steps, output
// when columns close faster than the back end clears them, the two-entry queue
// fills and req_stall rises on beats that would close a column; a held rsp_stall
// parks the back end at its output, so the queue can fill behind it and raise
// req_stall the same way; reset is synchronous; the column size returns to 256
// depends on wce_pkg, wce_front, wce_fifo, wce_back
module waveform_column_envelope import wce_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_data
);

   push_type     push;
   q_status_type q_status;
   job_type      head;
   logic         pop;

   assign csr_ready = 1'b1;

   // accumulate and classify
   wce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .push        (push)
   );

   // finished columns
   wce_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // divide and deliver
   wce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sv/wce_front.sv @@
// front end: column size register, per-sample accumulation, column completion
// depends on wce_pkg
module wce_front import wce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  csr_valid,
   input  logic [COUNT_BITS-1:0] csr_data,
   input  q_status_type          q_status,
   output push_type              push
);

   logic [COUNT_BITS-1:0]         column_size_ff, column_size_in;
   logic [PEAK_BITS-1:0]          peak_high_ff, peak_high_in;
   logic signed [SAMPLE_BITS-1:0] peak_low_ff, peak_low_in;
   logic [SUM_BITS-1:0]           pos_sum_ff, pos_sum_in;
   logic [SUM_BITS-1:0]           neg_mag_ff, neg_mag_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [COUNT_BITS-1:0]         column_ff, column_in;

   logic [COUNT_BITS-1:0]         size_eff;
   logic [COUNT_BITS-1:0]         count_next;
   logic                          col_done;
   logic                          accept;
   logic                          is_pos;
   logic                          is_neg;
   logic [SAMPLE_BITS:0]          mag;
   logic [PEAK_BITS-1:0]          peak_high_upd;
   logic signed [SAMPLE_BITS-1:0] peak_low_upd;
   logic [SUM_BITS-1:0]           pos_sum_upd;
   logic [SUM_BITS-1:0]           neg_mag_upd;

   // a zero size acts as one
   always_comb begin
      size_eff   = (column_size_ff == '0) ? COUNT_BITS'(1) : column_size_ff;
      count_next = count_ff + COUNT_BITS'(1);
      col_done   = (count_next >= size_eff);
      req_stall  = q_status.full & col_done;
      accept     = req_valid & ~req_stall;
   end

   // classify the sample and fold it into the running column
   always_comb begin
      is_pos = ~req_payload.sample[SAMPLE_BITS-1] && (req_payload.sample != '0);
      is_neg = req_payload.sample[SAMPLE_BITS-1];
      mag    = (SAMPLE_BITS+1)'(0) - {req_payload.sample[SAMPLE_BITS-1], req_payload.sample};

      peak_high_upd = peak_high_ff;
      pos_sum_upd   = pos_sum_ff;
      if (is_pos) begin
         if (req_payload.sample[PEAK_BITS-1:0] > peak_high_ff) begin
            peak_high_upd = req_payload.sample[PEAK_BITS-1:0];
         end
         pos_sum_upd = pos_sum_ff + SUM_BITS'(req_payload.sample[PEAK_BITS-1:0]);
      end

      peak_low_upd = peak_low_ff;
      neg_mag_upd  = neg_mag_ff;
      if (is_neg) begin
         if (req_payload.sample < peak_low_ff) begin
            peak_low_upd = req_payload.sample;
         end
         neg_mag_upd = neg_mag_ff + SUM_BITS'(mag);
      end
   end

   // hand a full column to the queue
   always_comb begin
      push.valid            = accept & col_done;
      push.job.column_index = column_ff;
      push.job.peak_high    = peak_high_upd;
      push.job.peak_low     = peak_low_upd;
      push.job.positive_sum = pos_sum_upd;
      push.job.negative_mag = neg_mag_upd;
      push.job.divisor      = size_eff;
   end

   // next column state
   always_comb begin
      column_size_in = csr_valid ? csr_data : column_size_ff;
      peak_high_in   = peak_high_ff;
      peak_low_in    = peak_low_ff;
      pos_sum_in     = pos_sum_ff;
      neg_mag_in     = neg_mag_ff;
      count_in       = count_ff;
      column_in      = column_ff;
      if (accept) begin
         if (col_done | req_payload.last_sample) begin
            peak_high_in = '0;
            peak_low_in  = '0;
            pos_sum_in   = '0;
            neg_mag_in   = '0;
            count_in     = '0;
         end else begin
            peak_high_in = peak_high_upd;
            peak_low_in  = peak_low_upd;
            pos_sum_in   = pos_sum_upd;
            neg_mag_in   = neg_mag_upd;
            count_in     = count_next;
         end
         if (req_payload.last_sample) begin
            column_in = '0;
         end else if (col_done) begin
            column_in = column_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_size_ff <= COLUMN_SIZE_RESET;
         peak_high_ff   <= '0;
         peak_low_ff    <= '0;
         pos_sum_ff     <= '0;
         neg_mag_ff     <= '0;
         count_ff       <= '0;
         column_ff      <= '0;
      end else begin
         column_size_ff <= column_size_in;
         peak_high_ff   <= peak_high_in;
         peak_low_ff    <= peak_low_in;
         pos_sum_ff     <= pos_sum_in;
         neg_mag_ff     <= neg_mag_in;
         count_ff       <= count_in;
         column_ff      <= column_in;
      end
   end

endmodule

@@ sv/wce_fifo.sv @@
// short queue of finished columns between front and back end
// depends on wce_pkg
module wce_fifo import wce_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output job_type      head,
   output q_status_type q_status
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   job_type               mem_ff [DEPTH];
   logic [ADDR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      q_status.full  = (fill_ff == CNT_BITS'(DEPTH));
      q_status.empty = (fill_ff == '0);
      head           = mem_ff[rd_ptr_ff];
      do_push        = push.valid & ~q_status.full;
      do_pop         = pop & ~q_status.empty;
   end

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + ADDR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + ADDR_BITS'(1);
      end
      if (do_push & ~do_pop) begin
         fill_in = fill_ff + CNT_BITS'(1);
      end else if (do_pop & ~do_push) begin
         fill_in = fill_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

@@ sv/wce_back.sv @@
// back end: radix-2 restoring divider for both column sums and the result register
// depends on wce_pkg
module wce_back import wce_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  job_type      head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_OUTPUT = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [COUNT_BITS-1:0]         div_ff, div_in;
   logic [SUM_BITS-1:0]           pos_q_ff, pos_q_in;
   logic [SUM_BITS-1:0]           neg_q_ff, neg_q_in;
   logic [COUNT_BITS-1:0]         pos_rem_ff, pos_rem_in;
   logic [COUNT_BITS-1:0]         neg_rem_ff, neg_rem_in;
   logic [COUNT_BITS-1:0]         column_ff, column_in;
   logic [PEAK_BITS-1:0]          peak_high_ff, peak_high_in;
   logic signed [SAMPLE_BITS-1:0] peak_low_ff, peak_low_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS:0]           pos_trial;
   logic [COUNT_BITS:0]           neg_trial;
   logic                          pos_ge;
   logic                          neg_ge;
   logic                          out_free;

   // one quotient bit per cycle for each sum
   always_comb begin
      pos_trial = {pos_rem_ff, pos_q_ff[SUM_BITS-1]};
      neg_trial = {neg_rem_ff, neg_q_ff[SUM_BITS-1]};
      pos_ge    = (pos_trial >= {1'b0, div_ff});
      neg_ge    = (neg_trial >= {1'b0, div_ff});
      out_free  = ~rsp_valid_ff | ~rsp_stall;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      div_in       = div_ff;
      pos_q_in     = pos_q_ff;
      neg_q_in     = neg_q_ff;
      pos_rem_in   = pos_rem_ff;
      neg_rem_in   = neg_rem_ff;
      column_in    = column_ff;
      peak_high_in = peak_high_ff;
      peak_low_in  = peak_low_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (~q_status.empty) begin
               pop          = 1'b1;
               div_in       = head.divisor;
               pos_q_in     = head.positive_sum;
               neg_q_in     = head.negative_mag;
               pos_rem_in   = '0;
               neg_rem_in   = '0;
               column_in    = head.column_index;
               peak_high_in = head.peak_high;
               peak_low_in  = head.peak_low;
               step_in      = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            pos_rem_in = pos_ge ? COUNT_BITS'(pos_trial - {1'b0, div_ff})
                                : pos_trial[COUNT_BITS-1:0];
            neg_rem_in = neg_ge ? COUNT_BITS'(neg_trial - {1'b0, div_ff})
                                : neg_trial[COUNT_BITS-1:0];
            pos_q_in   = {pos_q_ff[SUM_BITS-2:0], pos_ge};
            neg_q_in   = {neg_q_ff[SUM_BITS-2:0], neg_ge};
            step_in    = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.column_index = column_ff;
               rsp_data_in.peak_high    = peak_high_ff;
               rsp_data_in.peak_low     = peak_low_ff;
               rsp_data_in.average_high = pos_q_ff[PEAK_BITS-1:0];
               rsp_data_in.average_low  = SAMPLE_BITS'(0) - neg_q_ff[SAMPLE_BITS-1:0];
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      div_ff       <= div_in;
      pos_q_ff     <= pos_q_in;
      neg_q_ff     <= neg_q_in;
      pos_rem_ff   <= pos_rem_in;
      neg_rem_ff   <= neg_rem_in;
      column_ff    <= column_in;
      peak_high_ff <= peak_high_in;
      peak_low_ff  <= peak_low_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

@@ sv/wce_checker.sv @@
// port-level checks for the waveform column envelope, bound to the top level
// depends on wce_pkg and waveform_column_envelope_defines.svh
`include "waveform_column_envelope_defines.svh"

module wce_checker import wce_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_type               req_payload,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_payload,
   input logic                  csr_ready
);

   // a stalled result beat stays put
   `WCE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "result beat changed under stall")

   // a stalled sample beat stays put
   `WCE_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_payload), "req moved")

   // no result leaves straight after reset
   `WCE_ASSERT_AFTER_RESET(a_rsp_reset, !rsp_valid, "result valid after reset")

   // the low peak never goes positive
   `WCE_ASSERT_ALWAYS(a_peak_low_sign, !rsp_valid || rsp_payload.peak_low[SAMPLE_BITS-1] || rsp_payload.peak_low == '0, "positive low peak")

   // register writes are never held off
   `WCE_ASSERT_ALWAYS(a_csr_ready, csr_ready, "register port not ready")

endmodule

bind waveform_column_envelope wce_checker u_checker (.*);

@@ dv/wce_column_checker.sv @@
`timescale 1ns / 1ps
// column checker for the waveform column envelope: predicts every column from the
// sample beats, compares it with the result beats and counts failures; needs wce_pkg
module wce_column_checker import wce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_data,
   input  logic                  run_done,
   output int                    error_count,
   output int                    columns_pending,
   output int                    columns_checked
);

   // predicted column state and configured size
   logic [COUNT_BITS-1:0]         column_size;
   logic signed [SAMPLE_BITS-1:0] top_peak;
   logic signed [SAMPLE_BITS-1:0] bottom_peak;
   logic [SUM_BITS-1:0]           positive_total;
   logic [SUM_BITS-1:0]           negative_total;
   logic [COUNT_BITS-1:0]         column_fill;
   logic [COUNT_BITS-1:0]         column_number;
   rsp_type                       expected_columns[$];
   int                            mismatches = 0;
   int                            matched = 0;
   bit                            leftovers_counted = 1'b0;

   task automatic clear_column();
      top_peak       = '0;
      bottom_peak    = '0;
      positive_total = '0;
      negative_total = '0;
      column_fill    = '0;
   endtask

   // fold one sample beat into the column, queue the column once it is full
   task automatic fold_sample(input req_type beat);
      logic [SUM_BITS-1:0]        divisor;
      logic signed [SUM_BITS-1:0] widened;
      logic [SUM_BITS-1:0]        magnitude;
      logic [SUM_BITS-1:0]        low_mean;
      rsp_type                    column;
      // a size of zero behaves as one
      divisor = (column_size == '0) ? SUM_BITS'(1) : SUM_BITS'(column_size);
      widened = beat.sample;
      if (beat.sample > 0) begin
         if (beat.sample > top_peak) top_peak = beat.sample;
         positive_total = positive_total + widened;
      end else if (beat.sample < 0) begin
         if (beat.sample < bottom_peak) bottom_peak = beat.sample;
         negative_total = negative_total + widened;
      end
      column_fill = column_fill + 1'b1;

      // full column: averages truncate toward zero
      if (SUM_BITS'(column_fill) >= divisor) begin
         magnitude                 = '0 - negative_total;
         low_mean                  = '0 - (magnitude / divisor);
         column.column_index       = column_number;
         column.peak_high          = top_peak[PEAK_BITS-1:0];
         column.peak_low           = bottom_peak;
         column.average_high       = PEAK_BITS'(positive_total / divisor);
         column.average_low        = low_mean[SAMPLE_BITS-1:0];
         expected_columns.push_back(column);
         clear_column();
         column_number = column_number + 1'b1;
      end

      // end of track drops the partial column and restarts the index
      if (beat.last_sample) begin
         clear_column();
         column_number = '0;
      end
   endtask

   task automatic check_field(input string field, input logic signed [31:0] wanted,
                              input logic signed [31:0] seen);
      if (seen !== wanted) begin
         $error("%s: expected %0d, got %0d", field, wanted, seen);
         mismatches++;
      end
   endtask

   task automatic check_column(input rsp_type seen);
      rsp_type wanted;
      if (expected_columns.size() == 0) begin
         $error("result beat with no column pending, column_index %0d", seen.column_index);
         mismatches++;
      end else begin
         wanted = expected_columns.pop_front();
         check_field("column_index", wanted.column_index, seen.column_index);
         check_field("peak_high", wanted.peak_high, seen.peak_high);
         check_field("peak_low", wanted.peak_low, seen.peak_low);
         check_field("average_high", wanted.average_high, seen.average_high);
         check_field("average_low", wanted.average_low, seen.average_low);
         matched++;
      end
   endtask

   // results are checked before the sample of the same edge is folded in
   always @(posedge clock) begin
      if (reset) begin
         column_size = COLUMN_SIZE_RESET;
         clear_column();
         column_number = '0;
         expected_columns.delete();
      end else begin
         if (csr_valid && csr_ready) column_size = csr_data;
         if (rsp_valid && !rsp_stall) check_column(rsp_payload);
         if (req_valid && !req_stall) fold_sample(req_payload);
         if (run_done && !leftovers_counted) begin
            leftovers_counted = 1'b1;
            if (expected_columns.size() != 0) begin
               $error("%0d columns never arrived", expected_columns.size());
               mismatches += expected_columns.size();
            end
         end
      end
      error_count     <= mismatches;
      columns_pending <= expected_columns.size();
      columns_checked <= matched;
   end

endmodule

@@ dv/tb_waveform_column_envelope.sv @@
`timescale 1ns / 1ps
// top of the waveform column envelope testbench: clock, reset, sample and stall stimulus,
// column size writes and the verdict; needs wce_pkg, the block and wce_column_checker
module tb_waveform_column_envelope;
   import wce_pkg::*;

   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int DRAIN_LIMIT   = 20_000;
   localparam int SETTLE_CYCLES = 50;
   localparam int BIG_COLUMN    = 65535;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data = '0;
   logic                  run_done = 1'b0;

   int error_count;
   int columns_pending;
   int columns_checked;
   int beats_sent = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit sender_quiet = 1'b0;
   bit receiver_quiet = 1'b0;

   int unsigned column_sizes[13] = '{1, 2, 3, 5, 16, 33, 34, 35, 100, BIG_COLUMN, 0, 7, 1};

   waveform_column_envelope DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   wce_column_checker u_column_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .run_done        (run_done),
      .error_count     (error_count),
      .columns_pending (columns_pending),
      .columns_checked (columns_checked)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_waveform_column_envelope: done, errors");
         $finish;
      end
   end

   // idle lengths: mostly short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // sample values weighted toward the extremes, zero and one lsb
   function automatic int random_sample(input bit loud);
      int roll;
      roll = $urandom_range(0, 99);
      if (loud) begin
         if (roll < 45) return 32767;
         if (roll < 90) return -32768;
         return int'($urandom_range(0, 65535)) - 32768;
      end
      if (roll < 10) return 32767;
      if (roll < 20) return -32768;
      if (roll < 28) return 0;
      if (roll < 31) return 1;
      if (roll < 34) return -1;
      if (roll < 45) return int'($urandom_range(0, 127)) - 64;
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // receiver stalls, with quiet stretches
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         if ($urandom_range(0, 15) == 0) receiver_quiet = !receiver_quiet;
         if (receiver_quiet) begin
            rsp_stall  <= 1'b0;
            stall_left <= 30;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= pick_gap();
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
         end
      end
   end

   // one sample beat, held until accepted
   task automatic send_sample(input int value, input bit last);
      int      gap;
      req_type beat;
      if ($urandom_range(0, 63) == 0) sender_quiet = !sender_quiet;
      gap = sender_quiet ? 0 : pick_gap();
      beat.sample      = value[SAMPLE_BITS-1:0];
      beat.last_sample = last;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // stop sending until every predicted column is out or the drain limit runs out, then let the back end settle
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (columns_pending != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_column_size(input logic [COUNT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one track: random samples, end of track now and then, often on a column boundary
   task automatic random_phase(input int unsigned size, input int beats, input bit loud);
      int unsigned n;
      int unsigned fill;
      bit          last;
      n    = (size == 0) ? 1 : size;
      fill = 0;
      for (int i = 0; i < beats; i++) begin
         fill++;
         last = (i == beats - 1) || (!loud && $urandom_range(0, 49) == 0) ||
                (!loud && fill == n && $urandom_range(0, 5) == 0);
         if (last || fill == n) fill = 0;
         send_sample(random_sample(loud), last);
         if (!loud && $urandom_range(0, 149) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // column size straight out of reset
      random_phase(COLUMN_SIZE_RESET, 300, 1'b0);

      // columns of four: both extremes, silence, truncation toward zero
      write_column_size(COUNT_BITS'(4));
      send_sample(32767, 1'b0);
      send_sample(-32768, 1'b0);
      send_sample(0, 1'b0);
      send_sample(1, 1'b0);
      repeat (4) send_sample(0, 1'b0);
      repeat (3) send_sample(-1, 1'b0);
      send_sample(0, 1'b0);
      send_sample(1, 1'b0);
      send_sample(2, 1'b0);
      send_sample(0, 1'b0);
      send_sample(0, 1'b0);
      // partial column dropped at end of track, then one closed by the last beat
      send_sample(5, 1'b0);
      send_sample(-5, 1'b1);
      repeat (3) send_sample(7, 1'b0);
      send_sample(7, 1'b1);
      wait_drained();

      // zero size acts as one
      write_column_size('0);
      send_sample(100, 1'b0);
      send_sample(-32768, 1'b0);
      send_sample(0, 1'b1);
      wait_drained();

      // random tracks over every size, extreme samples at one of them
      foreach (column_sizes[k]) begin
         write_column_size(COUNT_BITS'(column_sizes[k]));
         random_phase(column_sizes[k], 60, column_sizes[k] == 33);
      end

      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      $display("covered %0d sample beats over %0d column size settings, zero and 65535 among them",
               beats_sent, $size(column_sizes) + 3);
      $display("%0d columns compared, with random gaps and stalls on both channels",
               columns_checked);
      if (error_count == 0) begin
         $display("tb_waveform_column_envelope: done, clean");
      end else begin
         $display("tb_waveform_column_envelope: done, errors");
      end
      $finish;
   end

endmodule
